### src/cseg_pkg.sv
// ----------------------------------------------------------------------------
// cseg_pkg: shared types and constants of the curve segment index generator
// Widths, codes, state and phase enums and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cseg_pkg;

   localparam int MAX_CURVE_VERTS = 32;
   localparam int REMAP_DEPTH     = 4096;
   localparam int IDX_W           = 31;
   localparam int CNT_W           = 6;
   localparam int OFF_W           = CNT_W + 1;
   localparam int ADDR_W          = 12;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 12;
   localparam int NUM_PHASES      = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUBIC_MODE   = 3'd0,
      CSR_BASIS        = 3'd1,
      CSR_WRAP_MODE    = 3'd2,
      CSR_REMAP_ENABLE = 3'd3,
      CSR_REMAP_LAST   = 3'd4
   } csr_index_type;

   localparam logic [1:0] BASIS_BEZIER  = 2'd0;
   localparam logic [1:0] BASIS_BSPLINE = 2'd1;
   localparam logic [1:0] BASIS_CATROM  = 2'd2;
   localparam logic [1:0] BASIS_CENTRIP = 2'd3;

   localparam logic [1:0] WRAP_NONPERIODIC = 2'd0;
   localparam logic [1:0] WRAP_PERIODIC    = 2'd1;
   localparam logic [1:0] WRAP_PINNED      = 2'd2;
   localparam logic [1:0] WRAP_SEGMENTED   = 2'd3;

   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_CURVE       = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_DRAIN,
      ST_PUSH
   } state_type;

   // segment kinds, in emission order
   typedef enum logic [2:0] {
      PH_PIN_B = 3'd0,
      PH_PIN_A = 3'd1,
      PH_MAIN  = 3'd2,
      PH_END_A = 3'd3,
      PH_END_B = 3'd4,
      PH_CLOSE = 3'd5
   } phase_type;

   typedef struct packed {
      logic                    operation;
      logic [CNT_W-1:0]        vertex_count;
      logic [ADDR_W-1:0]       table_address;
      logic [IDX_W-1:0]        table_value;
   } item_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   data;
   } csr_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0]        index0;
      logic [IDX_W-1:0]        index1;
      logic [IDX_W-1:0]        index2;
      logic [IDX_W-1:0]        index3;
      logic [IDX_W-1:0]        curve_id;
      logic                    last_segment;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic write_table;
      logic seg_init;
      logic issue;
      logic push;
      logic seg_adv;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip_curve;
      logic first_valid;
      logic next_valid;
      logic slot_last;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

### src/cseg_req_if.sv
// ----------------------------------------------------------------------------
// cseg_req_if: input item channel
// Valid/ready channel carrying one table write or one curve per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cseg_req_if;
   import cseg_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [CNT_W-1:0]    vertex_count;
   logic [ADDR_W-1:0]   table_address;
   logic [IDX_W-1:0]    table_value;

   modport source (output valid, output operation, output vertex_count,
                   output table_address, output table_value, input ready);
   modport sink   (input valid, input operation, input vertex_count,
                   input table_address, input table_value, output ready);
endinterface

`default_nettype wire

### src/cseg_rsp_if.sv
// ----------------------------------------------------------------------------
// cseg_rsp_if: segment result channel
// Valid/ready channel carrying one segment index tuple per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cseg_rsp_if;
   import cseg_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    index0;
   logic [IDX_W-1:0]    index1;
   logic [IDX_W-1:0]    index2;
   logic [IDX_W-1:0]    index3;
   logic [IDX_W-1:0]    curve_id;
   logic                last_segment;

   modport source (output valid, output index0, output index1, output index2,
                   output index3, output curve_id, output last_segment, input ready);
   modport sink   (input valid, input index0, input index1, input index2,
                   input index3, input curve_id, input last_segment, output ready);
endinterface

`default_nettype wire

### src/cseg_csr_if.sv
// ----------------------------------------------------------------------------
// cseg_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cseg_csr_if;
   import cseg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/cseg_ctrl.sv
// ----------------------------------------------------------------------------
// cseg_ctrl: sequencing state machine
// Accepts items, walks the segments of a curve and the slots of a segment.
// ----------------------------------------------------------------------------
`default_nettype none

module cseg_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_is_curve,
   output logic                           req_ready,
   input  wire cseg_pkg::ctrl_status_type status,
   output cseg_pkg::ctrl_cmd_type         cmd
);
   import cseg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_is_curve) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (status.skip_curve || !status.first_valid) state_in = ST_IDLE;
            else state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (status.slot_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) state_in = status.next_valid ? ST_ISSUE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_item   = req_valid && req_is_curve;
            cmd.write_table = req_valid && !req_is_curve;
         end
         ST_SETUP: begin
            cmd.commit   = !status.skip_curve && !status.first_valid;
            cmd.seg_init = !status.skip_curve && status.first_valid;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_PUSH: begin
            cmd.push    = status.out_free;
            cmd.seg_adv = status.out_free && status.next_valid;
            cmd.commit  = status.out_free && !status.next_valid;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### src/cseg_datapath.sv
// ----------------------------------------------------------------------------
// cseg_datapath: segment generation, translation and result register
// Holds configuration, counters, remap memory and the segment iterator.
// ----------------------------------------------------------------------------
`default_nettype none

module cseg_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cseg_pkg::item_type        item,
   input  wire logic                      csr_write,
   input  wire cseg_pkg::csr_wr_type      csr_wr,
   input  wire cseg_pkg::ctrl_cmd_type    cmd,
   output cseg_pkg::ctrl_status_type      status,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output cseg_pkg::rsp_type              rsp
);
   import cseg_pkg::*;

   localparam logic [IDX_W-1:0] DEPTH_LAST = IDX_W'(REMAP_DEPTH - 1);

   function automatic logic [OFF_W-1:0] min_off(input logic [OFF_W-1:0] a,
                                                input logic [OFF_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic main_ok(input logic [OFF_W-1:0] o, input logic cub,
                                    input logic [2:0] lim, input logic [CNT_W-1:0] n);
      logic [OFF_W:0] sum;
      sum = {1'b0, o} + (OFF_W+1)'(lim);
      return (cub && (o == '0)) || (sum <= (OFF_W+1)'(n));
   endfunction

   // configuration
   logic              cubic_ff, remap_en_ff;
   logic [1:0]        basis_ff, wrap_ff;
   logic [ADDR_W-1:0] remap_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cubic_ff      <= 1'b0;
         basis_ff      <= BASIS_BEZIER;
         wrap_ff       <= WRAP_NONPERIODIC;
         remap_en_ff   <= 1'b0;
         remap_last_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_wr.index)
            CSR_CUBIC_MODE:   cubic_ff      <= csr_wr.data[0];
            CSR_BASIS:        basis_ff      <= csr_wr.data[1:0];
            CSR_WRAP_MODE:    wrap_ff       <= csr_wr.data[1:0];
            CSR_REMAP_ENABLE: remap_en_ff   <= csr_wr.data[0];
            CSR_REMAP_LAST:   remap_last_ff <= csr_wr.data[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // curve parameters
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] base_ff, curve_ff;

   logic             bez, periodic, segmented, skip, pin, pin_b;
   logic [2:0]       step, lim;
   logic [OFF_W-1:0] start, last_v, offl;
   logic [IDX_W-1:0] adv;
   logic [NUM_PHASES-1:0] ex;

   always_comb begin
      bez       = (basis_ff == BASIS_BEZIER);
      periodic  = (wrap_ff == WRAP_PERIODIC);
      segmented = !cubic_ff && (wrap_ff == WRAP_SEGMENTED);
      skip      = ((basis_ff == BASIS_CATROM) || (basis_ff == BASIS_CENTRIP)) &&
                  (wrap_ff != WRAP_PINNED);
      pin       = cubic_ff && (wrap_ff == WRAP_PINNED) && !bez;
      pin_b     = pin && (basis_ff == BASIS_BSPLINE);
      if (cubic_ff) begin
         step = bez ? 3'd3 : 3'd1;
         lim  = periodic ? step : 3'd4;
      end else if (segmented) begin
         step = 3'd2;
         lim  = 3'd1;
      end else begin
         step = 3'd1;
         lim  = skip ? 3'd3 : 3'd2;
      end
      start  = (!cubic_ff && !segmented && skip) ? OFF_W'(1) : '0;
      last_v = OFF_W'(cnt_ff) - OFF_W'(1);
      offl   = (cnt_ff > CNT_W'(4)) ? OFF_W'(cnt_ff) - OFF_W'(4) : '0;
      if (cubic_ff) adv = IDX_W'(cnt_ff);
      else if (segmented) adv = IDX_W'(cnt_ff + CNT_W'(1)) & ~IDX_W'(1);
      else adv = (cnt_ff == '0) ? IDX_W'(1) : IDX_W'(cnt_ff);
      ex[PH_PIN_B] = pin_b;
      ex[PH_PIN_A] = pin;
      ex[PH_MAIN]  = main_ok(start, cubic_ff, lim, cnt_ff);
      ex[PH_END_A] = pin;
      ex[PH_END_B] = pin_b;
      ex[PH_CLOSE] = !cubic_ff && periodic;
   end

   // segment iterator
   phase_type        phase_ff, first_phase, nxt_phase;
   logic [OFF_W-1:0] off_ff, off_nxt;
   logic             first_found, nxt_found, main_more;
   logic [1:0]       slot_ff;

   always_comb begin
      first_found = 1'b0;
      first_phase = PH_CLOSE;
      nxt_found   = 1'b0;
      nxt_phase   = PH_CLOSE;
      for (int j = NUM_PHASES - 1; j >= 0; j--) begin
         if (ex[j]) begin
            first_found = 1'b1;
            first_phase = phase_type'(j);
         end
         if (ex[j] && (j > int'(phase_ff))) begin
            nxt_found = 1'b1;
            nxt_phase = phase_type'(j);
         end
      end
      off_nxt   = off_ff + OFF_W'(step);
      main_more = (phase_ff == PH_MAIN) && main_ok(off_nxt, cubic_ff, lim, cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cnt_ff <= (item.vertex_count > CNT_W'(MAX_CURVE_VERTS)) ?
                   CNT_W'(MAX_CURVE_VERTS) : item.vertex_count;
      end
      if (cmd.seg_init) begin
         phase_ff <= first_phase;
         off_ff   <= start;
      end else if (cmd.seg_adv) begin
         if (main_more) begin
            off_ff <= off_nxt;
         end else begin
            phase_ff <= nxt_phase;
            off_ff   <= start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         base_ff  <= '0;
         curve_ff <= '0;
      end else begin
         if (cmd.seg_init || cmd.seg_adv) slot_ff <= '0;
         else if (cmd.issue) slot_ff <= slot_ff + 2'd1;
         if (cmd.commit) begin
            base_ff  <= base_ff + adv;
            curve_ff <= curve_ff + IDX_W'(1);
         end
      end
   end

   // relative indices of the current segment
   logic [OFF_W-1:0] rel [4];
   logic [OFF_W-1:0] v1, v2, l1, l2, l3, x;

   always_comb begin
      v1 = min_off(OFF_W'(1), last_v);
      v2 = min_off(OFF_W'(2), last_v);
      l1 = min_off(offl + OFF_W'(1), last_v);
      l2 = min_off(offl + OFF_W'(2), last_v);
      l3 = min_off(offl + OFF_W'(3), last_v);
      for (int v = 0; v < 4; v++) rel[v] = '0;
      x = '0;
      unique case (phase_ff)
         PH_PIN_B: rel[3] = v1;
         PH_PIN_A: begin
            rel[2] = v1;
            rel[3] = v2;
         end
         PH_MAIN: begin
            if (cubic_ff) begin
               for (int v = 0; v < 4; v++) begin
                  x = off_ff + OFF_W'(v);
                  if (periodic) begin
                     if (x >= OFF_W'(cnt_ff)) x = x - OFF_W'(cnt_ff);
                     if (x >= OFF_W'(cnt_ff)) x = x - OFF_W'(cnt_ff);
                     rel[v] = x;
                  end else begin
                     rel[v] = min_off(x, last_v);
                  end
               end
            end else begin
               rel[0] = off_ff;
               rel[1] = off_ff + OFF_W'(1);
            end
         end
         PH_END_A: begin
            rel[0] = l1;
            rel[1] = l2;
            rel[2] = l3;
            rel[3] = l3;
         end
         PH_END_B: begin
            rel[0] = l2;
            rel[1] = l3;
            rel[2] = l3;
            rel[3] = l3;
         end
         PH_CLOSE: rel[0] = (cnt_ff == '0) ? '0 : last_v;
         default: begin
         end
      endcase
   end

   // translation: absolute index, then remap read
   logic [IDX_W-1:0]  idx, clamp, lim_w;
   logic [IDX_W-1:0]  remap_mem [REMAP_DEPTH];
   logic [IDX_W-1:0]  mem_q_ff, idx_q_ff;
   logic              cap_en_ff;
   logic [1:0]        cap_slot_ff;
   logic [IDX_W-1:0]  asm_ff [4];

   always_comb begin
      idx   = base_ff + IDX_W'(rel[slot_ff]);
      lim_w = (IDX_W'(remap_last_ff) < DEPTH_LAST) ? IDX_W'(remap_last_ff) : DEPTH_LAST;
      clamp = (idx < lim_w) ? idx : lim_w;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_table && (IDX_W'(item.table_address) < IDX_W'(REMAP_DEPTH))) begin
         remap_mem[item.table_address] <= item.table_value;
      end
      mem_q_ff <= remap_mem[clamp[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b0;
      end else begin
         cap_en_ff <= cmd.issue;
      end
      idx_q_ff    <= idx;
      cap_slot_ff <= slot_ff;
      if (cap_en_ff) asm_ff[cap_slot_ff] <= remap_en_ff ? mem_q_ff : idx_q_ff;
   end

   // result register
   logic    out_valid_ff;
   rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         out_ff.index0       <= asm_ff[0];
         out_ff.index1       <= asm_ff[1];
         out_ff.index2       <= cubic_ff ? asm_ff[2] : '0;
         out_ff.index3       <= cubic_ff ? asm_ff[3] : '0;
         out_ff.curve_id     <= curve_ff;
         out_ff.last_segment <= !(main_more || nxt_found);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      status.skip_curve  = cubic_ff && (cnt_ff < CNT_W'(2));
      status.first_valid = first_found;
      status.next_valid  = main_more || nxt_found;
      status.slot_last   = cubic_ff ? (slot_ff == 2'd3) : (slot_ff == 2'd1);
      status.out_free    = !out_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

### src/curve_segment_index_generator.sv
// ----------------------------------------------------------------------------
// curve_segment_index_generator: curve segment index tuple generator
// Turns per-curve vertex counts into segment index tuples, optionally remapped.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  carries one beat per item: operation 0 writes one remap table
//           entry (no result), operation 1 processes one curve.
//   rsp_ch  carries one beat per segment: four indices (lines use only the
//           first two, the rest read zero), the curve number and a flag on
//           the curve's final segment.
//   csr_ch  writes configuration registers by index; always ready. Write
//           only while the block is idle.
// Flow: a curve is accepted and set up, then each segment reads its index
//   slots (four for cubic, two for lines) in turn through the single remap
//   read port, then drains and loads the result register.
// Reset clears configuration, the vertex base and the curve counter; the
//   remap table holds nothing until written.
// A stalled receiver holds the result register; generation of the next
//   segment runs ahead and waits until the register frees. The next item is
//   accepted once the final segment sits in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module curve_segment_index_generator (
   input  wire logic  clock,
   input  wire logic  reset,
   cseg_req_if.sink   req_ch,
   cseg_rsp_if.source rsp_ch,
   cseg_csr_if.sink   csr_ch
);
   import cseg_pkg::*;

   item_type        item;
   csr_wr_type      csr_wr;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   rsp_type         rsp;
   logic            rsp_valid;

   // gather the request payload into one bundle for the datapath
   assign item = '{operation:     req_ch.operation,
                   vertex_count:  req_ch.vertex_count,
                   table_address: req_ch.table_address,
                   table_value:   req_ch.table_value};

   // configuration registers take every write; never hold the port
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = '{index: csr_ch.index, data: csr_ch.data};

   cseg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_is_curve (req_ch.operation == OP_CURVE),
      .req_ready    (req_ch.ready),
      .status       (status),
      .cmd          (cmd)
   );

   cseg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .csr_write (csr_ch.valid),
      .csr_wr    (csr_wr),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp       (rsp)
   );

   // drive the result channel straight from the result register
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.index0       = rsp.index0;
   assign rsp_ch.index1       = rsp.index1;
   assign rsp_ch.index2       = rsp.index2;
   assign rsp_ch.index3       = rsp.index3;
   assign rsp_ch.curve_id     = rsp.curve_id;
   assign rsp_ch.last_segment = rsp.last_segment;

endmodule

`default_nettype wire
